FILE: rtl/jct_pkg.sv
// ----------------------------------------------------------------------------
// jct_pkg: shared types and constants of the JSON character tokenizer
// Token kinds, run modes, the token record and the queue entry that holds
// every token one character beat causes.
// ----------------------------------------------------------------------------
package jct_pkg;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef enum logic [3:0] {
		KIND_LBRACE  = 4'd0,
		KIND_RBRACE  = 4'd1,
		KIND_QUOTE   = 4'd2,
		KIND_COLON   = 4'd3,
		KIND_COMMA   = 4'd4,
		KIND_INTEGER = 4'd5,
		KIND_MINUS   = 4'd6,
		KIND_PERIOD  = 4'd7,
		KIND_WORD    = 4'd8,
		KIND_END     = 4'd9,
		KIND_UNDEF   = 4'd10
	} token_kind_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_WORD   = 2'd2,
		MODE_UNDEF  = 2'd3
	} run_mode_t;

	typedef struct packed {
		token_kind_t kind;
		logic [15:0] start;
		logic [15:0] len;
	} token_t;

	// One queue entry per character beat that gives at least one token.
	typedef struct packed {
		logic   two;     // second token valid
		token_t first;
		token_t second;
	} entry_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DIG_LO = 8'd47;
	localparam logic [7:0] CH_DIG_HI = 8'd58;

endpackage

FILE: rtl/jct_front.sv
// ----------------------------------------------------------------------------
// jct_front: character classifier and run tracker
// Classifies each accepted character, keeps the open run and the position,
// and builds the queue entry of the tokens that the character causes.
// ----------------------------------------------------------------------------
module jct_front #(
	parameter int OFFSET_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      char_byte,
	output logic            push,
	output jct_pkg::entry_t entry
);

	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] run_start_q;
	logic [15:0]            run_len_q;
	jct_pkg::run_mode_t     mode_q;

	logic [OFFSET_BITS+15:0] pos_ext;
	logic [OFFSET_BITS+15:0] start_ext;

	logic                   is_digit, is_letter, run_open, run_ends, absorb;
	logic                   has_single, is_ws, is_nul;
	jct_pkg::token_kind_t   single_kind, run_kind;
	jct_pkg::run_mode_t     open_mode;
	jct_pkg::token_t        run_tok, single_tok;

	assign pos_ext   = {16'b0, pos_q};
	assign start_ext = {16'b0, run_start_q};

	assign is_digit  = (char_byte > jct_pkg::CH_DIG_LO) && (char_byte < jct_pkg::CH_DIG_HI);
	assign is_letter = (char_byte >= 8'h61 && char_byte <= 8'h7A)
		|| (char_byte >= 8'h41 && char_byte <= 8'h5A);

	assign run_open = (mode_q != jct_pkg::MODE_NONE);
	assign run_ends = (mode_q == jct_pkg::MODE_NUMBER) ? !is_digit
		: (char_byte == jct_pkg::CH_QUOTE || char_byte == jct_pkg::CH_NUL);
	assign absorb   = run_open && !run_ends;

	// Character decoder
	always_comb begin
		has_single  = 1'b1;
		single_kind = jct_pkg::KIND_LBRACE;
		is_ws       = 1'b0;
		is_nul      = 1'b0;
		unique case (char_byte)
			jct_pkg::CH_LBRACE: single_kind = jct_pkg::KIND_LBRACE;
			jct_pkg::CH_RBRACE: single_kind = jct_pkg::KIND_RBRACE;
			jct_pkg::CH_QUOTE:  single_kind = jct_pkg::KIND_QUOTE;
			jct_pkg::CH_COLON:  single_kind = jct_pkg::KIND_COLON;
			jct_pkg::CH_COMMA:  single_kind = jct_pkg::KIND_COMMA;
			jct_pkg::CH_MINUS:  single_kind = jct_pkg::KIND_MINUS;
			jct_pkg::CH_PERIOD: single_kind = jct_pkg::KIND_PERIOD;
			jct_pkg::CH_NUL: begin
				single_kind = jct_pkg::KIND_END;
				is_nul      = 1'b1;
			end
			jct_pkg::CH_SPACE, jct_pkg::CH_TAB, jct_pkg::CH_CR, jct_pkg::CH_LF: begin
				has_single = 1'b0;
				is_ws      = 1'b1;
			end
			default: has_single = 1'b0;
		endcase
	end

	// Mode of a run opened by this character
	always_comb begin
		if (has_single || is_ws)
			open_mode = jct_pkg::MODE_NONE;
		else if (is_digit)
			open_mode = jct_pkg::MODE_NUMBER;
		else if (is_letter)
			open_mode = jct_pkg::MODE_WORD;
		else
			open_mode = jct_pkg::MODE_UNDEF;
	end

	always_comb begin
		unique case (mode_q)
			jct_pkg::MODE_NUMBER: run_kind = jct_pkg::KIND_INTEGER;
			jct_pkg::MODE_WORD:   run_kind = jct_pkg::KIND_WORD;
			default:              run_kind = jct_pkg::KIND_UNDEF;
		endcase
	end

	always_comb begin
		run_tok.kind  = run_kind;
		run_tok.start = start_ext[15:0];
		run_tok.len   = run_len_q;

		single_tok.kind  = single_kind;
		single_tok.start = pos_ext[15:0];
		single_tok.len   = is_nul ? 16'd0 : 16'd1;

		entry.two    = run_open && has_single;
		entry.first  = run_open ? run_tok : single_tok;
		entry.second = single_tok;
	end

	assign push = take && !absorb && (run_open || has_single);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			run_start_q <= '0;
			run_len_q   <= '0;
			mode_q      <= jct_pkg::MODE_NONE;
		end else if (take) begin
			if (absorb) begin
				if (run_len_q != jct_pkg::LEN_MAX)
					run_len_q <= run_len_q + 16'd1;
				pos_q <= pos_q + 1'b1;
			end else begin
				mode_q <= open_mode;
				if (open_mode != jct_pkg::MODE_NONE) begin
					run_start_q <= pos_q;
					run_len_q   <= 16'd1;
				end else begin
					run_len_q <= '0;
				end
				pos_q <= is_nul ? '0 : pos_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/jct_queue.sv
// ----------------------------------------------------------------------------
// jct_queue: token entry queue
// Short FIFO between classifier and token sequencer.
// ----------------------------------------------------------------------------
module jct_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jct_pkg::entry_t wr_entry,
	input  logic            pop,
	output jct_pkg::entry_t rd_entry,
	output logic            not_empty,
	output logic            full
);

	jct_pkg::entry_t              mem_q [jct_pkg::Q_DEPTH];
	logic [jct_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [jct_pkg::Q_CNT_W-1:0]  count_q;

	assign full      = (count_q == jct_pkg::Q_CNT_W'(jct_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/jct_back.sv
// ----------------------------------------------------------------------------
// jct_back: token sequencer
// Holds one queue entry and sends its one or two tokens, one per beat.
// ----------------------------------------------------------------------------
module jct_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  jct_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      token_kind,
	output logic [15:0]     start_offset,
	output logic [15:0]     token_length,
	output logic            last_result
);

	logic            cur_valid_q;
	jct_pkg::entry_t cur_q;
	logic            sel_q;       // 1: second token showing
	logic            beat, finish, load;
	jct_pkg::token_t tok;

	assign beat   = cur_valid_q && out_ready;
	assign finish = beat && (sel_q || !cur_q.two);
	assign load   = !cur_valid_q || finish;
	assign q_pop  = load && q_valid;

	assign tok          = sel_q ? cur_q.second : cur_q.first;
	assign out_valid    = cur_valid_q;
	assign token_kind   = tok.kind;
	assign start_offset = tok.start;
	assign token_length = tok.len;
	assign last_result  = sel_q || !cur_q.two;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			cur_valid_q <= q_valid;
			sel_q       <= 1'b0;
		end else if (beat) begin
			sel_q <= 1'b1;
		end
	end

endmodule

FILE: rtl/json_char_tokenizer.sv
// ----------------------------------------------------------------------------
// json_char_tokenizer: byte-serial JSON lexer
// Takes one character per beat and gives tokens as kind, start offset and
// length; a character may close a run and give its own token as well.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------
//  in       | input     | in_valid / in_ready | char_byte
//  out      | output    | out_valid/out_ready | token_kind, start_offset,
//           |           |                     | token_length, last_result
//
// One character is taken every clock while the queue has room. A character
// that gives two tokens sends them on separate beats; the 4-entry queue
// takes up the difference, so the output sets the long-run rate at one
// token per clock while out_ready stays high. A taken character's tokens
// pass through the queue and the sequencer's holding register to out_valid.
// arst_n clears the run state, the position, the queue and the output.
// in_ready depends only on queue fill, never on out_ready in the same cycle.
//
// Structure: jct_front classifies and tracks the open run, jct_queue
// buffers token entries, jct_back hands the tokens out one by one.
// ----------------------------------------------------------------------------
module json_char_tokenizer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic        last_result
);

	logic            take, push, pop, q_full, q_nonempty;
	jct_pkg::entry_t wr_entry, rd_entry;

	// Accept whenever the queue can hold one more entry.
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	jct_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.char_byte(char_byte),
		.push     (push),
		.entry    (wr_entry)
	);

	jct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.not_empty(q_nonempty),
		.full     (q_full)
	);

	jct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_nonempty),
		.q_entry     (rd_entry),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.last_result (last_result)
	);

endmodule

FILE: rtl/jct_checker.sv
// ----------------------------------------------------------------------------
// jct_checker: port-level checks of the tokenizer
// Output hold under stall and token shape rules per kind.
// ----------------------------------------------------------------------------
module jct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  token_kind,
	input logic [15:0] start_offset,
	input logic [15:0] token_length,
	input logic        last_result
);

	// Stalled token holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind)
		&& $stable(start_offset) && $stable(token_length) && $stable(last_result))
		else $error("token changed under stall");

	// End token is empty and closes its character.
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == jct_pkg::KIND_END |-> token_length == 16'd0 && last_result)
		else $error("bad end token");

	// Single-character tokens are one long and always last.
	a_single_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == jct_pkg::KIND_LBRACE || token_kind == jct_pkg::KIND_RBRACE
		|| token_kind == jct_pkg::KIND_QUOTE || token_kind == jct_pkg::KIND_COLON
		|| token_kind == jct_pkg::KIND_COMMA || token_kind == jct_pkg::KIND_MINUS
		|| token_kind == jct_pkg::KIND_PERIOD) |-> token_length == 16'd1 && last_result)
		else $error("bad single-character token");

	// Run tokens are never empty.
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == jct_pkg::KIND_INTEGER || token_kind == jct_pkg::KIND_WORD
		|| token_kind == jct_pkg::KIND_UNDEF) |-> token_length != 16'd0)
		else $error("empty run token");

endmodule

bind json_char_tokenizer jct_checker u_jct_checker (.*);
